/* rtl/core/knn_pkg.sv */
package knn_pkg;

  typedef struct packed {
    logic       opcode;
    logic [3:0] class_label;
    logic signed [7:0] rssi_0;
    logic signed [7:0] rssi_1;
    logic signed [7:0] rssi_2;
    logic signed [7:0] rssi_3;
  } knn_in_t;

  typedef struct packed {
    logic [3:0] predicted_label;
    logic       store_empty;
    logic       store_full;
    logic [8:0] entry_count;
  } knn_out_t;

  typedef enum logic {
    OP_QUERY = 1'b0,
    OP_STORE = 1'b1
  } knn_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_VOTE,
    ST_PICK,
    ST_OUT
  } knn_state_e;

  localparam int unsigned CfgW    = 5;
  localparam int unsigned LabelW  = 4;
  localparam int unsigned DistW   = 19;
  localparam int unsigned RssiW   = 8;
  localparam int unsigned CountW  = 9;

endpackage

/* rtl/core/knn_ram.sv */
module knn_ram #(
  parameter int unsigned Width = 36,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* rtl/core/knn_front.sv */
// Front: accept items into a two-entry queue.
module knn_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             stall_o,
  input  knn_pkg::knn_in_t data_i,
  output logic             q_valid_o,
  input  logic             q_pop_i,
  output knn_pkg::knn_in_t q_data_o
);
  import knn_pkg::*;

  knn_in_t     buf_q [2];
  logic        wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push;

  assign stall_o   = (cnt_q == 2'd2);
  assign push      = valid_i && !stall_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o  = buf_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q ^ push;
    rptr_d = rptr_q ^ q_pop_i;
    cnt_d  = cnt_q + {1'b0, push} - {1'b0, q_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wptr_q] <= data_i;
    end
  end
endmodule

/* rtl/core/knn_back.sv */
// Back: store append or query scan, insertion list, vote, pick.
module knn_back #(
  parameter int unsigned StoreDepth    = 256,
  parameter int unsigned NumAnchors    = 4,
  parameter int unsigned NumLabels     = 16,
  parameter int unsigned MaxNeighbours = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [knn_pkg::CfgW-1:0]   k_cfg_i,
  input  logic                       q_valid_i,
  output logic                       q_pop_o,
  input  knn_pkg::knn_in_t           q_data_i,
  output logic                       valid_o,
  input  logic                       stall_i,
  output knn_pkg::knn_out_t          data_o
);
  import knn_pkg::*;

  localparam int unsigned AddrW  = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam int unsigned EntW   = LabelW + 4 * RssiW;
  localparam int unsigned NbW    = $clog2(MaxNeighbours + 1);
  localparam int unsigned NbIdxW = (MaxNeighbours > 1) ? $clog2(MaxNeighbours) : 1;
  localparam int unsigned LblN   = 16;

  knn_state_e state_q, state_d;
  knn_in_t    item_q;
  logic [CountW-1:0] count_q;
  logic [CountW-1:0] idx_q, idx_d;
  logic       rd_valid_q;
  logic [3:0] lbl_q;
  logic [NbW-1:0] k_q, have_q;
  logic [DistW-1:0]  nd_q [MaxNeighbours];
  logic [LabelW-1:0] nl_q [MaxNeighbours];
  logic [4:0]  votes_q [LblN];
  logic [4:0]  best_v_q;
  logic [3:0]  best_l_q;
  logic        full_q;
  knn_out_t    out_q;
  logic        out_valid_q;

  logic [EntW-1:0] rdata;
  logic        we;
  logic [AddrW-1:0] raddr;
  logic        fetch;

  // Stage 1: per-anchor difference squared, registered
  logic [DistW-1:0] sq_q [4];
  logic [LabelW-1:0] s1_lbl_q;
  logic        s1_valid_q;
  logic [DistW-1:0] dist_sum;
  logic [RssiW-1:0] ent_r [4];
  logic [RssiW-1:0] qry_r [4];

  knn_ram #(.Width(EntW), .Depth(StoreDepth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i ({item_q.class_label, item_q.rssi_0, item_q.rssi_1,
               item_q.rssi_2, item_q.rssi_3}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign ent_r[0] = rdata[31:24];
  assign ent_r[1] = rdata[23:16];
  assign ent_r[2] = rdata[15:8];
  assign ent_r[3] = rdata[7:0];
  assign qry_r[0] = item_q.rssi_0;
  assign qry_r[1] = item_q.rssi_1;
  assign qry_r[2] = item_q.rssi_2;
  assign qry_r[3] = item_q.rssi_3;
  assign raddr    = idx_q[AddrW-1:0];
  assign fetch    = (state_q == ST_SCAN) && item_q.opcode == OP_QUERY
                    && (idx_q < count_q);

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 4; a++) begin
      logic signed [RssiW:0] df;
      logic signed [2*RssiW+1:0] sq;
      df = $signed({ent_r[a][RssiW-1], ent_r[a]}) - $signed({qry_r[a][RssiW-1], qry_r[a]});
      sq = df * df;
      if (a < NumAnchors) begin
        sq_q[a] <= DistW'($unsigned(sq));
      end else begin
        sq_q[a] <= '0;
      end
    end
    s1_lbl_q <= rdata[EntW-1 -: LabelW];
  end

  assign dist_sum = sq_q[0] + sq_q[1] + sq_q[2] + sq_q[3];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (q_valid_i && !out_valid_q) state_d = ST_SCAN;
      ST_SCAN: begin
        if (item_q.opcode == OP_STORE || count_q == '0) state_d = ST_OUT;
        else if (idx_q + 1'b1 >= count_q) state_d = ST_DRAIN;
      end
      ST_DRAIN: if (!rd_valid_q && !s1_valid_q) state_d = ST_VOTE;
      ST_VOTE:  if (lbl_q == 4'(MaxNeighbours - 1)) state_d = ST_PICK;
      ST_PICK:  if (lbl_q == 4'(LblN - 1)) state_d = ST_OUT;
      ST_OUT:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop_o = (state_q == ST_IDLE) && q_valid_i && !out_valid_q;
    we      = (state_q == ST_SCAN) && item_q.opcode == OP_STORE
              && count_q < CountW'(StoreDepth);
    idx_d   = q_pop_o ? '0 : (fetch ? idx_q + 1'b1 : idx_q);
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      rd_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_valid_q <= fetch;
      s1_valid_q <= rd_valid_q;
      if (we) count_q <= count_q + 1'b1;
      if (out_valid_q && !stall_i) out_valid_q <= 1'b0;
      if (state_q == ST_OUT) out_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [NbW-1:0] p;
    p = '0;
    idx_q <= idx_d;
    if (q_pop_o) begin
      item_q <= q_data_i;
      have_q <= '0;
      lbl_q  <= '0;
      best_v_q <= '0;
      best_l_q <= '0;
      for (int j = 0; j < LblN; j++) votes_q[j] <= '0;
      if (k_cfg_i == '0) k_q <= NbW'(1);
      else if (k_cfg_i > CfgW'(MaxNeighbours)) k_q <= NbW'(MaxNeighbours);
      else k_q <= NbW'(k_cfg_i);
    end
    if (state_q == ST_SCAN) begin
      full_q <= item_q.opcode == OP_STORE && !we;
    end
    if (s1_valid_q) begin
      // insertion position: first slot with distance >= new one
      for (int m = 0; m < MaxNeighbours; m++) begin
        if (NbW'(m) < have_q && nd_q[m] < dist_sum) p = NbW'(m + 1);
      end
      if (p < k_q) begin
        if (have_q < k_q) have_q <= have_q + 1'b1;
        for (int m = 1; m < MaxNeighbours; m++) begin
          if (NbW'(m) > p) begin
            nd_q[m] <= nd_q[m-1];
            nl_q[m] <= nl_q[m-1];
          end
        end
        nd_q[p[NbIdxW-1:0]] <= dist_sum;
        nl_q[p[NbIdxW-1:0]] <= s1_lbl_q;
      end
    end
    if (state_q == ST_VOTE) begin
      if (NbW'(lbl_q) < have_q && 32'(nl_q[lbl_q]) < NumLabels)
        votes_q[nl_q[lbl_q]] <= votes_q[nl_q[lbl_q]] + 1'b1;
      lbl_q <= (lbl_q == 4'(MaxNeighbours - 1)) ? '0 : lbl_q + 1'b1;
    end
    if (state_q == ST_PICK) begin
      if (votes_q[lbl_q] > best_v_q) begin
        best_v_q <= votes_q[lbl_q];
        best_l_q <= lbl_q;
      end
      lbl_q <= lbl_q + 1'b1;
    end
    if (state_q == ST_OUT) begin
      out_q.entry_count <= count_q;
      out_q.store_full  <= full_q;
      out_q.store_empty <= item_q.opcode == OP_QUERY && count_q == '0;
      out_q.predicted_label <= (item_q.opcode == OP_QUERY && count_q != '0)
                               ? best_l_q : '0;
    end
  end
endmodule

/* rtl/core/knn_fingerprint_classifier_unit.sv */
// k-nearest-neighbor fingerprint classifier.
// Input channel valid_i/stall_o carries one transaction: opcode (store or
// query), label and four RSSI values. Output channel valid_o/stall_i carries
// one result per transaction: label, empty and full flags, entry count.
// A store result becomes valid after the scan and output states. A query
// scans every stored fingerprint through one RAM read port, one per cycle,
// then steps the vote over MAX_NEIGHBOURS slots and picks over 16 labels.
// A two-entry queue in front accepts transactions while the back end works.
// neighbour_count_we_i writes the neighbor count (reset 3); the user writes it only while idle, unchecked.
// Reset empties the store and the queue; stored contents are not cleared.
// While stall_i is high the result holds and the back end waits; the input
// queue keeps taking transactions until it fills.
module knn_fingerprint_classifier_unit #(
  parameter int unsigned STORE_DEPTH    = 256,
  parameter int unsigned NUM_ANCHORS    = 4,
  parameter int unsigned NUM_LABELS     = 16,
  parameter int unsigned MAX_NEIGHBOURS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     stall_o,
  input  knn_pkg::knn_in_t         data_i,
  output logic                     valid_o,
  input  logic                     stall_i,
  output knn_pkg::knn_out_t        data_o,
  input  logic                     neighbour_count_we_i,
  input  logic [knn_pkg::CfgW-1:0] neighbour_count_i
);
  import knn_pkg::*;

  logic [CfgW-1:0] k_q;
  logic            q_valid, q_pop;
  knn_in_t         q_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) k_q <= CfgW'(3);
    else if (neighbour_count_we_i) k_q <= neighbour_count_i;
  end

  knn_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .data_i,
    .q_valid_o (q_valid), .q_pop_i (q_pop), .q_data_o (q_data)
  );

  knn_back #(
    .StoreDepth (STORE_DEPTH), .NumAnchors (NUM_ANCHORS),
    .NumLabels (NUM_LABELS), .MaxNeighbours (MAX_NEIGHBOURS)
  ) u_back (
    .clk_i, .rst_ni, .k_cfg_i (k_q),
    .q_valid_i (q_valid), .q_pop_o (q_pop), .q_data_i (q_data),
    .valid_o, .stall_i, .data_o
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> data_o.entry_count <= 9'(STORE_DEPTH))
    else $error("entry count beyond store depth");
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !(data_o.store_empty && data_o.store_full))
    else $error("empty and full together");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(data_o))
    else $error("stalled result changed");
endmodule
